/* sv/assert_macros.svh */
// Assertion macros shared by the line assembler modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define HLA_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error("line assembler assertion failed");
`define HLA_ASSERT_IMPL(lbl, clk, rst_n, pre, post) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
		else $error("line assembler assertion failed");
`else
`define HLA_ASSERT(lbl, clk, rst_n, prop)
`define HLA_ASSERT_IMPL(lbl, clk, rst_n, pre, post)
`endif
`endif

/* sv/hla_pkg.sv */
// Types, codes and mnemonic lookup tables of the line assembler.
package hla_pkg;

	localparam int TOKEN_CHARS = 4;
	localparam int TLEN_W      = $clog2(TOKEN_CHARS + 1);
	localparam int TIDX_W      = $clog2(TOKEN_CHARS);
	localparam int ACC_W       = 15;
	localparam int SUM_W       = 19;

	localparam logic [2:0] PH_START = 3'd0;
	localparam logic [2:0] PH_ADDR  = 3'd1;
	localparam logic [2:0] PH_FIRST = 3'd2;
	localparam logic [2:0] PH_COMP  = 3'd3;
	localparam logic [2:0] PH_JUMP  = 3'd4;

	localparam logic [7:0] CH_AT   = "@";
	localparam logic [7:0] CH_EQ   = "=";
	localparam logic [7:0] CH_SEMI = ";";
	localparam logic [7:0] CH_D0   = "0";
	localparam logic [7:0] CH_D9   = "9";

	localparam logic [SUM_W-1:0] ADDR_MAX = SUM_W'(32767);
	localparam logic [2:0]       C_PREFIX = 3'b111;

	typedef logic [TOKEN_CHARS-1:0][7:0] tok_t;
	typedef logic [TLEN_W-1:0]           tlen_t;
	typedef logic [25:0]                 key_t;

	typedef struct packed {
		logic       valid;
		logic [7:0] char_code;
		logic       line_last;
	} beat_t;

	typedef struct packed {
		logic        valid;
		logic [15:0] word;
		logic        bad;
	} res_t;

	// Pack a token of up to three characters with its length; longer or
	// empty tokens give the all-zero key, which matches no mnemonic.
	function automatic key_t tok_key(tok_t tok, tlen_t len);
		key_t k;
		k = '0;
		if (len == TLEN_W'(1))
			k = {2'd1, tok[0], 16'h0000};
		else if (len == TLEN_W'(2))
			k = {2'd2, tok[0], tok[1], 8'h00};
		else if (len == TLEN_W'(3))
			k = {2'd3, tok[0], tok[1], tok[2]};
		return k;
	endfunction

	// Returns {hit, code}.
	function automatic logic [3:0] dest_lookup(tok_t tok, tlen_t len);
		logic [3:0] r;
		case (tok_key(tok, len))
			{2'd1, "M", 16'h0000}: r = {1'b1, 3'd1};
			{2'd1, "D", 16'h0000}: r = {1'b1, 3'd2};
			{2'd2, "MD", 8'h00}:   r = {1'b1, 3'd3};
			{2'd1, "A", 16'h0000}: r = {1'b1, 3'd4};
			{2'd2, "AM", 8'h00}:   r = {1'b1, 3'd5};
			{2'd2, "AD", 8'h00}:   r = {1'b1, 3'd6};
			{2'd3, "AMD"}:         r = {1'b1, 3'd7};
			default:               r = 4'h0;
		endcase
		return r;
	endfunction

	function automatic logic [3:0] jump_lookup(tok_t tok, tlen_t len);
		logic [3:0] r;
		case (tok_key(tok, len))
			{2'd3, "JGT"}: r = {1'b1, 3'd1};
			{2'd3, "JEQ"}: r = {1'b1, 3'd2};
			{2'd3, "JGE"}: r = {1'b1, 3'd3};
			{2'd3, "JLT"}: r = {1'b1, 3'd4};
			{2'd3, "JNE"}: r = {1'b1, 3'd5};
			{2'd3, "JLE"}: r = {1'b1, 3'd6};
			{2'd3, "JMP"}: r = {1'b1, 3'd7};
			default:       r = 4'h0;
		endcase
		return r;
	endfunction

	function automatic logic [7:0] comp_lookup(tok_t tok, tlen_t len);
		logic [7:0] r;
		case (tok_key(tok, len))
			{2'd1, "0", 16'h0000}: r = {1'b1, 7'b0101010};
			{2'd1, "1", 16'h0000}: r = {1'b1, 7'b0111111};
			{2'd2, "-1", 8'h00}:   r = {1'b1, 7'b0111010};
			{2'd1, "D", 16'h0000}: r = {1'b1, 7'b0001100};
			{2'd1, "A", 16'h0000}: r = {1'b1, 7'b0110000};
			{2'd2, "!D", 8'h00}:   r = {1'b1, 7'b0001101};
			{2'd2, "!A", 8'h00}:   r = {1'b1, 7'b0110001};
			{2'd2, "-D", 8'h00}:   r = {1'b1, 7'b0001111};
			{2'd2, "-A", 8'h00}:   r = {1'b1, 7'b0110011};
			{2'd3, "D+1"}:         r = {1'b1, 7'b0011111};
			{2'd3, "A+1"}:         r = {1'b1, 7'b0110111};
			{2'd3, "D-1"}:         r = {1'b1, 7'b0001110};
			{2'd3, "A-1"}:         r = {1'b1, 7'b0110010};
			{2'd3, "D+A"}:         r = {1'b1, 7'b0000010};
			{2'd3, "D-A"}:         r = {1'b1, 7'b0010011};
			{2'd3, "A-D"}:         r = {1'b1, 7'b0000111};
			{2'd3, "D&A"}:         r = {1'b1, 7'b0000000};
			{2'd3, "D|A"}:         r = {1'b1, 7'b0010101};
			{2'd1, "M", 16'h0000}: r = {1'b1, 7'b1110000};
			{2'd2, "!M", 8'h00}:   r = {1'b1, 7'b1110001};
			{2'd2, "-M", 8'h00}:   r = {1'b1, 7'b1110011};
			{2'd3, "M+1"}:         r = {1'b1, 7'b1110111};
			{2'd3, "M-1"}:         r = {1'b1, 7'b1110010};
			{2'd3, "D+M"}:         r = {1'b1, 7'b1000010};
			{2'd3, "D-M"}:         r = {1'b1, 7'b1010011};
			{2'd3, "M-D"}:         r = {1'b1, 7'b1000111};
			{2'd3, "D&M"}:         r = {1'b1, 7'b1000000};
			{2'd3, "D|M"}:         r = {1'b1, 7'b1010101};
			default:               r = 8'h00;
		endcase
		return r;
	endfunction

endpackage

/* sv/hla_if.sv */
// Valid/ready channel interfaces for characters in and words out.
interface hla_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] char_code;
	logic       line_last;

	modport source (output valid, output char_code, output line_last, input ready);
	modport sink (input valid, input char_code, input line_last, output ready);
endinterface

interface hla_out_if;
	logic        valid;
	logic        ready;
	logic [15:0] machine_word;
	logic        bad_line;

	modport source (output valid, output machine_word, output bad_line, input ready);
	modport sink (input valid, input machine_word, input bad_line, output ready);
endinterface

/* sv/hla_in_stage.sv */
// Input register: captures one character beat per cycle unless it holds a beat that is not advanced.
module hla_in_stage (
	input  logic           clk,
	input  logic           arst_n,
	hla_in_if.sink         chars,
	input  logic           advance,
	output hla_pkg::beat_t beat_s1
);

	logic       valid_s1;
	logic [7:0] char_s1;
	logic       last_s1;
	logic       take;

	assign chars.ready = !valid_s1 || advance;
	assign take        = chars.valid && chars.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (chars.ready) begin
			valid_s1 <= chars.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			char_s1 <= chars.char_code;
			last_s1 <= chars.line_last;
		end
	end

	assign beat_s1 = '{valid: valid_s1, char_code: char_s1, line_last: last_s1};

endmodule

/* sv/hla_line_core.sv */
// Line state and instruction encoding: one character per advance.
`include "assert_macros.svh"
module hla_line_core (
	input  logic           clk,
	input  logic           arst_n,
	input  hla_pkg::beat_t beat_s1,
	input  logic           advance,
	output hla_pkg::res_t  res
);

	logic [2:0]                 phase_q, n_phase, eff_phase;
	logic [hla_pkg::ACC_W-1:0]  acc_q, n_acc;
	hla_pkg::tok_t              tok_q, n_tok;
	hla_pkg::tlen_t             len_q, n_len;
	logic [2:0]                 dest_q, n_dest;
	logic [6:0]                 comp_q, n_comp;
	logic                       err_q, n_err;
	logic [hla_pkg::SUM_W-1:0]  acc_sum;
	logic [7:0]                 c;
	logic                       is_digit;
	logic [3:0]                 dest_hit, jump_hit;
	logic [7:0]                 comp_cur, comp_fin;
	logic                       fin_err;
	logic [15:0]                word;

	assign c        = beat_s1.char_code;
	assign is_digit = (c >= hla_pkg::CH_D0) && (c <= hla_pkg::CH_D9);
	assign acc_sum  = {1'b0, acc_q, 3'b000} + {3'b000, acc_q, 1'b0}
		+ hla_pkg::SUM_W'(c - hla_pkg::CH_D0);
	assign eff_phase = (phase_q == hla_pkg::PH_START) ? hla_pkg::PH_FIRST : phase_q;
	assign dest_hit  = hla_pkg::dest_lookup(tok_q, len_q);
	assign comp_cur  = hla_pkg::comp_lookup(tok_q, len_q);

	always_comb begin
		n_phase = phase_q;
		n_acc   = acc_q;
		n_tok   = tok_q;
		n_len   = len_q;
		n_dest  = dest_q;
		n_comp  = comp_q;
		n_err   = err_q;
		if (phase_q == hla_pkg::PH_START && c == hla_pkg::CH_AT) begin
			n_phase = hla_pkg::PH_ADDR;
		end else if (phase_q == hla_pkg::PH_ADDR) begin
			if (is_digit) begin
				// keep the old address on overflow
				if (acc_sum > hla_pkg::ADDR_MAX)
					n_err = 1'b1;
				else
					n_acc = acc_sum[hla_pkg::ACC_W-1:0];
				n_len = hla_pkg::TLEN_W'(1);
			end else begin
				n_err = 1'b1;
			end
		end else begin
			n_phase = eff_phase;
			if (c == hla_pkg::CH_EQ) begin
				if (eff_phase == hla_pkg::PH_FIRST) begin
					n_dest  = dest_hit[2:0];
					n_err   = err_q | !dest_hit[3];
					n_len   = '0;
					n_phase = hla_pkg::PH_COMP;
				end else begin
					n_err = 1'b1;
				end
			end else if (c == hla_pkg::CH_SEMI) begin
				if (eff_phase == hla_pkg::PH_FIRST || eff_phase == hla_pkg::PH_COMP) begin
					n_comp  = comp_cur[6:0];
					n_err   = err_q | !comp_cur[7];
					n_len   = '0;
					n_phase = hla_pkg::PH_JUMP;
				end else begin
					n_err = 1'b1;
				end
			end else if (len_q < hla_pkg::TLEN_W'(hla_pkg::TOKEN_CHARS)) begin
				n_tok[len_q[hla_pkg::TIDX_W-1:0]] = c;
				n_len = len_q + hla_pkg::TLEN_W'(1);
			end else begin
				n_err = 1'b1;
			end
		end
	end

	// Final lookups see the token with this beat's character appended.
	assign jump_hit = hla_pkg::jump_lookup(n_tok, n_len);
	assign comp_fin = hla_pkg::comp_lookup(n_tok, n_len);

	always_comb begin
		if (n_phase == hla_pkg::PH_ADDR) begin
			fin_err = n_err | (n_len == '0);
			word    = {1'b0, n_acc};
		end else if (n_phase == hla_pkg::PH_JUMP) begin
			fin_err = n_err | !jump_hit[3];
			word    = {hla_pkg::C_PREFIX, n_comp, n_dest, jump_hit[2:0]};
		end else begin
			fin_err = n_err | !comp_fin[7];
			word    = {hla_pkg::C_PREFIX, comp_fin[6:0], n_dest, 3'b000};
		end
	end

	assign res = '{valid: advance && beat_s1.line_last,
		word: fin_err ? 16'h0000 : word, bad: fin_err};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= hla_pkg::PH_START;
			acc_q   <= '0;
			len_q   <= '0;
			dest_q  <= '0;
			comp_q  <= '0;
			err_q   <= 1'b0;
		end else if (advance) begin
			if (beat_s1.line_last) begin
				// drop all line state once the word is out
				phase_q <= hla_pkg::PH_START;
				acc_q   <= '0;
				len_q   <= '0;
				dest_q  <= '0;
				comp_q  <= '0;
				err_q   <= 1'b0;
			end else begin
				phase_q <= n_phase;
				acc_q   <= n_acc;
				len_q   <= n_len;
				dest_q  <= n_dest;
				comp_q  <= n_comp;
				err_q   <= n_err;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance)
			tok_q <= n_tok;
	end

	`HLA_ASSERT(a_len_bound, clk, arst_n, len_q <= hla_pkg::TLEN_W'(hla_pkg::TOKEN_CHARS))
	`HLA_ASSERT_IMPL(a_clear_after_word, clk, arst_n, res.valid, ##1 (phase_q == hla_pkg::PH_START && len_q == '0 && !err_q))
	`HLA_ASSERT_IMPL(a_bad_is_zero, clk, arst_n, res.valid && res.bad, res.word == 16'h0000)
	`HLA_ASSERT_IMPL(a_addr_no_fields, clk, arst_n, phase_q == hla_pkg::PH_ADDR, dest_q == '0 && comp_q == '0)

endmodule

/* sv/hla_out_reg.sv */
// Output register holding one assembled word until taken.
`include "assert_macros.svh"
module hla_out_reg (
	input  logic          clk,
	input  logic          arst_n,
	input  hla_pkg::res_t res,
	output logic          free,
	hla_out_if.source     words
);

	logic        valid_q;
	logic [15:0] word_q;
	logic        bad_q;

	assign free = !valid_q || words.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (res.valid) begin
			valid_q <= 1'b1;
		end else if (words.ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res.valid) begin
			word_q <= res.word;
			bad_q  <= res.bad;
		end
	end

	assign words.valid        = valid_q;
	assign words.machine_word = word_q;
	assign words.bad_line     = bad_q;

	`HLA_ASSERT_IMPL(a_no_overwrite, clk, arst_n, res.valid, !valid_q || words.ready)
	`HLA_ASSERT_IMPL(a_load_shows, clk, arst_n, res.valid, ##1 valid_q)
	`HLA_ASSERT_IMPL(a_bad_word_zero, clk, arst_n, valid_q && bad_q, word_q == 16'h0000)

endmodule

/* sv/hack_line_assembler.sv */
// Top level of the line assembler: input register, line core, output register.
//
//  channel | dir | beat payload                   | beats
//  chars   | in  | char_code[7:0], line_last      | one per character
//  words   | out | machine_word[15:0], bad_line   | one per line, on the last character
//
// A character beat can be taken every cycle while the core advances; the input
// register feeds the line core, which updates state and forms the word into the
// output register, so each word follows its last character through both registers.
// arst_n clears the line state and both valid flags; no clearing pass.
// A stalled words channel stops the core; chars.ready falls only once the
// input register also holds a beat.
module hack_line_assembler (
	input  logic      clk,
	input  logic      arst_n,
	hla_in_if.sink    chars,
	hla_out_if.source words
);

	hla_pkg::beat_t beat_s1;
	hla_pkg::res_t  res;
	logic           free;
	logic           advance;

	assign advance = beat_s1.valid && free;

	hla_in_stage u_in (
		.clk     (clk),
		.arst_n  (arst_n),
		.chars   (chars),
		.advance (advance),
		.beat_s1 (beat_s1)
	);

	hla_line_core u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.beat_s1 (beat_s1),
		.advance (advance),
		.res     (res)
	);

	hla_out_reg u_out (
		.clk    (clk),
		.arst_n (arst_n),
		.res    (res),
		.free   (free),
		.words  (words)
	);

endmodule
